FILE: rtl/spjm_pkg.sv
// Shared constants, configuration codes and bundle types of the period jitter monitor.
package spjm_pkg;

    localparam int STAMP_W     = 32;
    localparam int ERR_W       = 10;
    localparam int RUN_LEN_W   = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int DEF_MAX_RUN = 1024;

    localparam logic [ERR_W-1:0]     ERR_MAX         = ERR_W'(1023);
    localparam logic [STAMP_W-1:0]   RST_TARGET      = STAMP_W'(8000);
    localparam logic [STAMP_W-1:0]   RST_ALLOWANCE   = STAMP_W'(8);
    localparam logic [RUN_LEN_W-1:0] RST_RUN_LENGTH  = RUN_LEN_W'(1000);
    localparam logic [RUN_LEN_W-1:0] MIN_RUN_LENGTH  = RUN_LEN_W'(2);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWANCE     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LENGTH    = CFG_IDX_W'(2);

    typedef struct packed {
        logic [STAMP_W-1:0]   target_period;
        logic [STAMP_W-1:0]   allowance;
        logic [RUN_LEN_W-1:0] run_length;
    } t_cfg;

    typedef struct packed {
        logic [ERR_W-1:0]   error_count;
        logic [STAMP_W-1:0] jitter;
    } t_result;

endpackage

FILE: rtl/spjm_stamp_if.sv
// Valid/ready channel carrying one time stamp per item.
interface spjm_stamp_if;
    logic                        valid;
    logic                        ready;
    logic [spjm_pkg::STAMP_W-1:0] stamp;

    modport source (output valid, output stamp, input ready);
    modport sink   (input valid, input stamp, output ready);
endinterface

FILE: rtl/spjm_result_if.sv
// Valid/ready channel carrying one run summary per item.
interface spjm_result_if;
    logic                        valid;
    logic                        ready;
    logic [spjm_pkg::ERR_W-1:0]   error_count;
    logic [spjm_pkg::STAMP_W-1:0] jitter;

    modport source (output valid, output error_count, output jitter, input ready);
    modport sink   (input valid, input error_count, input jitter, output ready);
endinterface

FILE: rtl/sample_period_jitter_monitor_unit.sv
// Top level of the sample period jitter monitor.
//
// Usage:
//   i_stamp carries one elapsed-time stamp per sample event; an item is taken
//   when valid and ready are both high. Each stamp after the first of a run
//   forms a period, the wrapping difference from the stamp before it.
//   o_result carries one item at the end of every run: the number of periods
//   outside target_period +/- allowance (saturating at 1023) and the jitter,
//   the greatest minus the least period of the run.
//   Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data; index 0 is
//   target_period, 1 allowance, 2 run_length. Write only while idle.
// Timing:
//   One stamp per cycle sustained while no run-ending stamp holds (below).
//   A taken stamp has its period registered in the period stage; as it moves
//   on, the run statistics step and a run end loads the result register.
//   The rate is set by the single accumulator update per cycle.
// Reset and stall:
//   Reset clears the run, the stored stamp and both pipeline stages, and
//   loads the register defaults 8000, 8 and 1000. While a summary waits on
//   o_result, stamps that end no run still flow; a stamp that would end the
//   next run holds in the period stage until the summary is taken.
module sample_period_jitter_monitor_unit #(
    parameter int MAX_RUN = spjm_pkg::DEF_MAX_RUN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    spjm_stamp_if.sink                      i_stamp,
    spjm_result_if.source                   o_result,
    input  logic                            i_cfg_we,
    input  logic [spjm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [spjm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import spjm_pkg::*;

    // Configuration registers
    t_cfg               r_cfg;

    // Period stage
    logic               r_a_valid;
    logic [STAMP_W-1:0] r_a_period;
    logic [STAMP_W-1:0] r_last_stamp;

    // Result register
    logic               r_o_valid;
    t_result            r_o_result;

    logic               in_take;
    logic               acc_step;
    logic               acc_done;
    logic               out_free;
    t_result            acc_result;

    // Configuration writes; drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_period <= RST_TARGET;
            r_cfg.allowance     <= RST_ALLOWANCE;
            r_cfg.run_length    <= RST_RUN_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET_PERIOD: r_cfg.target_period <= i_cfg_data[STAMP_W-1:0];
                CFG_ALLOWANCE:     r_cfg.allowance     <= i_cfg_data[STAMP_W-1:0];
                CFG_RUN_LENGTH:    r_cfg.run_length    <= i_cfg_data[RUN_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the accumulator unless its run summary has nowhere to go
    assign out_free       = !r_o_valid || o_result.ready;
    assign acc_step       = r_a_valid && (!acc_done || out_free);
    assign i_stamp.ready  = !r_a_valid || acc_step;
    assign in_take        = i_stamp.valid && i_stamp.ready;

    // Period stage: the previous stamp is simply the last item taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_last_stamp <= '0;
        end else begin
            if (in_take) begin
                r_a_valid    <= 1'b1;
                r_last_stamp <= i_stamp.stamp;
            end else if (acc_step) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_period <= i_stamp.stamp - r_last_stamp;
        end
    end

    spjm_run_acc #(
        .MAX_RUN (MAX_RUN)
    ) u_run_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (acc_step),
        .i_period (r_a_period),
        .i_cfg    (r_cfg),
        .o_done   (acc_done),
        .o_result (acc_result)
    );

    // Result register: load at run end, clear when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (acc_step && acc_done) begin
            r_o_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_step && acc_done) begin
            r_o_result <= acc_result;
        end
    end

    assign o_result.valid       = r_o_valid;
    assign o_result.error_count = r_o_result.error_count;
    assign o_result.jitter      = r_o_result.jitter;

    // A finished run never overwrites a summary still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_step && acc_done) |-> (!r_o_valid || o_result.ready))
        else $error("run summary overwritten");

    // A new stamp enters the period stage only when the held one moves on
    a_no_stage_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && r_a_valid) |-> acc_step)
        else $error("period stage item lost");

    // A taken stamp is always held in the period stage at the next edge
    a_stage_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_a_valid)
        else $error("taken stamp not held");

endmodule

FILE: rtl/spjm_run_acc.sv
// Run accumulator: error count, least and greatest period, run end detection.
module spjm_run_acc #(
    parameter int MAX_RUN = spjm_pkg::DEF_MAX_RUN
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [spjm_pkg::STAMP_W-1:0] i_period,
    input  spjm_pkg::t_cfg               i_cfg,
    output logic                         o_done,
    output spjm_pkg::t_result            o_result
);
    import spjm_pkg::*;

    localparam int IW = $clog2(MAX_RUN + 1);
    localparam int CW = (IW > RUN_LEN_W) ? IW : RUN_LEN_W;

    logic [IW-1:0]      r_index;
    logic [ERR_W-1:0]   r_errors;
    logic [STAMP_W-1:0] r_least;
    logic [STAMP_W-1:0] r_greatest;

    logic [IW-1:0]      n_index;
    logic [ERR_W-1:0]   n_errors;
    logic [STAMP_W-1:0] n_least;
    logic [STAMP_W-1:0] n_greatest;

    logic [CW-1:0]      run_len_ext;
    logic [CW-1:0]      eff_len;
    logic [IW-1:0]      idx_inc;
    logic [STAMP_W-1:0] band_hi;
    logic [STAMP_W-1:0] band_lo;
    logic               out_of_band;
    logic               below_least;
    logic               above_greatest;
    logic               has_period;
    logic               first_period;
    logic [STAMP_W-1:0] jitter;

    // Clamp the run length into the supported range
    always_comb begin
        run_len_ext = CW'(i_cfg.run_length);
        if (run_len_ext < CW'(MIN_RUN_LENGTH)) begin
            eff_len = CW'(MIN_RUN_LENGTH);
        end else if (run_len_ext > CW'(MAX_RUN)) begin
            eff_len = CW'(MAX_RUN);
        end else begin
            eff_len = run_len_ext;
        end
    end

    assign idx_inc        = r_index + IW'(1);
    assign o_done         = CW'(idx_inc) >= eff_len;
    assign has_period     = r_index != '0;
    assign first_period   = r_index == IW'(1);
    assign band_hi        = i_period + i_cfg.allowance;
    assign band_lo        = i_period - i_cfg.allowance;
    assign out_of_band    = (band_hi < i_cfg.target_period) || (band_lo > i_cfg.target_period);
    assign below_least    = i_period < r_least;
    assign above_greatest = i_period > r_greatest;

    always_comb begin
        n_errors   = r_errors;
        n_least    = r_least;
        n_greatest = r_greatest;
        jitter     = r_greatest - r_least;
        if (has_period) begin
            if (out_of_band && (r_errors != ERR_MAX)) begin
                n_errors = r_errors + ERR_W'(1);
            end
            if (first_period) begin
                n_least    = i_period;
                n_greatest = i_period;
                jitter     = '0;
            end else if (above_greatest) begin
                n_greatest = i_period;
                jitter     = i_period - r_least;
            end else if (below_least) begin
                n_least = i_period;
                jitter  = r_greatest - i_period;
            end
        end
        n_index = idx_inc;
        if (o_done) begin
            n_index    = '0;
            n_errors   = '0;
            n_least    = '0;
            n_greatest = '0;
        end
    end

    assign o_result.error_count = (has_period && out_of_band && (r_errors != ERR_MAX)) ?
                                  r_errors + ERR_W'(1) : r_errors;
    assign o_result.jitter      = jitter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index    <= '0;
            r_errors   <= '0;
            r_least    <= '0;
            r_greatest <= '0;
        end else if (i_step) begin
            r_index    <= n_index;
            r_errors   <= n_errors;
            r_least    <= n_least;
            r_greatest <= n_greatest;
        end
    end

endmodule

FILE: tb/sv/spjm_run_checker.sv
// Run-summary predictor and comparator for the sample period jitter monitor.
module spjm_run_checker #(
    parameter int MAX_RUN = spjm_pkg::DEF_MAX_RUN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    spjm_stamp_if                           i_stamp,
    spjm_result_if                          i_result,
    input  logic                            i_cfg_we,
    input  logic [spjm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [spjm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_mismatches,
    output int                              o_pending
);
    import spjm_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [STAMP_W-1:0]   target_q;
    logic [STAMP_W-1:0]   allow_q;
    logic [RUN_LEN_W-1:0] run_len_q;
    logic [STAMP_W-1:0]   prev_stamp;
    logic [STAMP_W-1:0]   least_q;
    logic [STAMP_W-1:0]   greatest_q;
    logic [ERR_W-1:0]     errors_q;
    int unsigned          stamps_in_run;
    t_result              summary_q[$];
    int                   mismatch_count = 0;

    function automatic int unsigned run_limit(input logic [RUN_LEN_W-1:0] len);
        if (len < MIN_RUN_LENGTH)
            return MIN_RUN_LENGTH;
        if (len > MAX_RUN)
            return MAX_RUN;
        return len;
    endfunction

    task automatic clear_run;
        stamps_in_run = 0;
        errors_q      = '0;
        least_q       = '0;
        greatest_q    = '0;
    endtask

    // Advance the run statistics by one stamp; queue a summary when the run ends.
    task automatic take_stamp(input logic [STAMP_W-1:0] stamp);
        logic [STAMP_W-1:0] period;
        logic [STAMP_W-1:0] upper;
        logic [STAMP_W-1:0] lower;
        t_result            summary;
        int unsigned        limit;
        limit = run_limit(run_len_q);
        if (stamps_in_run != 0) begin
            period = stamp - prev_stamp;
            upper  = period + allow_q;
            lower  = period - allow_q;
            if ((upper < target_q) || (lower > target_q)) begin
                if (errors_q != ERR_MAX)
                    errors_q = errors_q + 1'b1;
            end
            if (stamps_in_run == 1) begin
                least_q    = period;
                greatest_q = period;
            end else begin
                if (period < least_q)
                    least_q = period;
                if (period > greatest_q)
                    greatest_q = period;
            end
        end
        prev_stamp    = stamp;
        stamps_in_run = stamps_in_run + 1;
        if (stamps_in_run >= limit) begin
            summary.error_count = errors_q;
            summary.jitter      = greatest_q - least_q;
            summary_q.push_back(summary);
            clear_run();
        end
    endtask

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < REPORT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count = mismatch_count + 1;
    endtask

    always @(posedge i_clk) begin
        t_result expected;
        if (!i_rst_n) begin
            target_q   = RST_TARGET;
            allow_q    = RST_ALLOWANCE;
            run_len_q  = RST_RUN_LENGTH;
            prev_stamp = '0;
            clear_run();
            summary_q.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (summary_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected summary errors %0d jitter %0d",
                                            i_result.error_count, i_result.jitter));
                end else begin
                    expected = summary_q.pop_front();
                    if (i_result.error_count !== expected.error_count)
                        flag_mismatch($sformatf("error_count expected %0d got %0d",
                                                expected.error_count, i_result.error_count));
                    if (i_result.jitter !== expected.jitter)
                        flag_mismatch($sformatf("jitter expected %0d got %0d",
                                                expected.jitter, i_result.jitter));
                end
            end
            if (i_stamp.valid && i_stamp.ready)
                take_stamp(i_stamp.stamp);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TARGET_PERIOD: target_q  = i_cfg_data;
                    CFG_ALLOWANCE:     allow_q   = i_cfg_data;
                    CFG_RUN_LENGTH:    run_len_q = i_cfg_data[RUN_LEN_W-1:0];
                    default: ;
                endcase
            end
        end
        o_mismatches = mismatch_count;
        o_pending    = summary_q.size();
    end

endmodule

FILE: tb/sv/tb_sample_period_jitter_monitor_unit.sv
// Testbench top for the sample period jitter monitor: stimulus, flow control and verdict.
module tb_sample_period_jitter_monitor_unit;
    import spjm_pkg::*;

    // Index past the three registers; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 40;
    localparam int LONG_PHASE  = 9;    // length above the largest, cut short by the next phase
    localparam int LONG_ITEMS  = 420;
    localparam int WIDE_PHASE  = 14;   // largest legal length, cut short by the next phase
    localparam int HOLD_PHASE  = 2;    // receiver holds off while stamps keep coming
    localparam int LONG_HOLD   = 300;
    localparam int NOISE_PCT   = 15;
    localparam int SETTLE      = 6;    // period stage, then result register; leave margin

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int gap_pct      = 0;
    int stall_pct    = 0;
    int hold_asked   = 0;    // bumped by the stimulus for each hold-off it wants
    int hold_served  = 0;    // hold-offs started by the ready driver
    int hold_left    = 0;
    int mismatches;
    int pending;

    // Mirror of what was last sent and programmed, used to shape well-formed stamps.
    logic [STAMP_W-1:0] last_sent  = '0;
    logic [STAMP_W-1:0] cur_target = RST_TARGET;
    logic [STAMP_W-1:0] cur_allow  = RST_ALLOWANCE;

    spjm_stamp_if  stamp_ch ();
    spjm_result_if result_ch ();

    sample_period_jitter_monitor_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stamp    (stamp_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    spjm_run_checker u_run_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stamp      (stamp_ch),
        .i_result     (result_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Drive ready: a requested hold-off takes priority, counted here cycle by cycle;
    // otherwise stall at the current percentage.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            result_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_served) begin
            result_ch.ready <= 1'b0;
            hold_left   <= LONG_HOLD - 1;
            hold_served <= hold_asked;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one stamp, with random idle cycles ahead of it, and hold it until taken.
    task automatic send_stamp(input logic [STAMP_W-1:0] value);
        while ($urandom_range(99) < gap_pct) begin
            stamp_ch.valid <= 1'b0;
            stamp_ch.stamp <= $urandom;
            @(posedge i_clk);
        end
        stamp_ch.valid <= 1'b1;
        stamp_ch.stamp <= value;
        @(posedge i_clk);
        while (!stamp_ch.ready)
            @(posedge i_clk);
        last_sent = value;
    endtask

    // Drop valid, wait for every queued summary, then let the pipeline empty.
    task automatic settle;
        stamp_ch.valid <= 1'b0;
        do
            @(negedge i_clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write all three registers plus the spare index; call only while idle.
    task automatic program_regs(input logic [STAMP_W-1:0]   tgt,
                                input logic [STAMP_W-1:0]   alw,
                                input logic [RUN_LEN_W-1:0] len);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_TARGET_PERIOD;
        cfg_data <= tgt;
        @(posedge i_clk);
        cfg_idx  <= CFG_ALLOWANCE;
        cfg_data <= alw;
        @(posedge i_clk);
        // Upper bits beyond the run length field must be dropped by the block.
        cfg_idx  <= CFG_RUN_LENGTH;
        cfg_data <= {(CFG_DATA_W-RUN_LEN_W)'($urandom), len};
        @(posedge i_clk);
        cfg_idx  <= CFG_SPARE;
        cfg_data <= $urandom;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        cur_target = tgt;
        cur_allow  = alw;
    endtask

    // Next stamp: mostly one target period on, landing on the target, on or just
    // past the band edges or within 32 of the target; the rest fully random.
    function automatic logic [STAMP_W-1:0] next_stamp(input int noise_pct);
        logic [STAMP_W-1:0] step;
        if ($urandom_range(99) < noise_pct)
            return $urandom;
        case ($urandom_range(5))
            0:       step = cur_target;
            1:       step = cur_target + cur_allow;
            2:       step = cur_target - cur_allow;
            3:       step = cur_target + cur_allow + STAMP_W'(1);
            4:       step = cur_target - cur_allow - STAMP_W'(1);
            default: step = cur_target + STAMP_W'($urandom_range(64)) - STAMP_W'(32);
        endcase
        return last_sent + step;
    endfunction

    initial begin
        logic [STAMP_W-1:0]   band_edges [14];
        logic [STAMP_W-1:0]   tgt;
        logic [STAMP_W-1:0]   alw;
        logic [RUN_LEN_W-1:0] len;
        int                   count;
        int                   noise;

        stamp_ch.valid  <= 1'b0;
        stamp_ch.stamp  <= '0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_TARGET_PERIOD;
        cfg_data        <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Run length 0 acts as 2: every pair of stamps is one run. Hit both band
        // edges and one tick past each, a period that wraps through zero, a zero
        // period and the largest period.
        program_regs(STAMP_W'(8000), STAMP_W'(8), RUN_LEN_W'(0));
        band_edges = '{32'h0000_0000, 32'h0000_1F38,
                       32'h0000_0000, 32'h0000_1F37,
                       32'h0000_0064, 32'h0000_1FAC,
                       32'h0000_0064, 32'h0000_1FAD,
                       32'hFFFF_FFF0, 32'h0000_1F30,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'h0000_0000, 32'hFFFF_FFFF};
        foreach (band_edges[i])
            send_stamp(band_edges[i]);
        settle();

        // Run length 1 acts as 2; all-ones target and allowance wrap both sums.
        program_regs('1, '1, RUN_LEN_W'(1));
        send_stamp(STAMP_W'(7));
        send_stamp(STAMP_W'(7));
        send_stamp(32'h1234_5678);
        send_stamp(32'h8765_4321);
        settle();

        // Lower the run length mid-run: the next stamp ends the run.
        program_regs(STAMP_W'(100), '0, RUN_LEN_W'(10));
        send_stamp(STAMP_W'(0));
        send_stamp(STAMP_W'(100));
        send_stamp(STAMP_W'(200));
        send_stamp(STAMP_W'(301));
        send_stamp(STAMP_W'(399));
        send_stamp(STAMP_W'(500));
        settle();
        program_regs(STAMP_W'(100), '0, RUN_LEN_W'(3));
        send_stamp(STAMP_W'(600));
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            // Rotate the idling pattern across phases.
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 52; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 52; end
                default: begin gap_pct = 14; stall_pct = 14; end
            endcase

            case ($urandom_range(4))
                0, 1:    tgt = STAMP_W'($urandom_range(20000));
                2:       tgt = '0;
                3:       tgt = '1;
                default: tgt = $urandom;
            endcase
            case ($urandom_range(3))
                0:       alw = '0;
                1:       alw = STAMP_W'($urandom_range(64));
                2:       alw = '1;
                default: alw = $urandom;
            endcase
            len   = RUN_LEN_W'($urandom_range(12));
            count = PHASE_ITEMS;
            noise = NOISE_PCT;

            if (phase == LONG_PHASE) begin
                // Length above the maximum clamps to it; random stamps against a
                // zero band make nearly every period an error. The next phase
                // lowers the length, so its first stamp ends this long run.
                tgt   = '0;
                alw   = '0;
                len   = '1;
                count = LONG_ITEMS;
                noise = 100;
            end else if (phase == WIDE_PHASE) begin
                len = RUN_LEN_W'(DEF_MAX_RUN);
            end
            program_regs(tgt, alw, len);

            if (phase == HOLD_PHASE) begin
                // Hold the receiver off long enough for the block to back up.
                @(negedge i_clk);
                hold_asked = hold_asked + 1;
                @(posedge i_clk);
            end

            for (int n = 0; n < count; n++)
                send_stamp(next_stamp(noise));
            settle();
        end

        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
rtl/spjm_pkg.sv
rtl/spjm_stamp_if.sv
rtl/spjm_result_if.sv
rtl/spjm_run_acc.sv
rtl/sample_period_jitter_monitor_unit.sv
tb/sv/spjm_run_checker.sv
tb/sv/tb_sample_period_jitter_monitor_unit.sv
